[src/prq_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the ready queue.
package prq_pkg;

   localparam int NUM_LEVELS  = 64;
   localparam int NUM_THREADS = 64;
   localparam int ID_W        = 6;
   localparam int LVL_W       = 6;
   localparam int GRP_SIZE    = 8;
   localparam int SUB_W       = 3;
   localparam int NUM_GRPS    = NUM_LEVELS / GRP_SIZE;
   localparam int GRP_W       = LVL_W - SUB_W;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_MOVE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_ALREADY = 2'd2;
   localparam logic [1:0] ST_NOTQ    = 2'd3;

   typedef struct packed {
      logic       load;
      logic       find_grp;
      logic       find_lvl;
      logic       rd_thr;
      logic       rd_lvl;
      logic       lvl_sel_old;
      logic       t_from_head;
      logic       unlink;
      logic       append;
      logic       respond;
      logic [1:0] rsp_status;
      logic       rsp_zero;
      logic       rsp_lvl_old;
   } prq_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       queued;
      logic       bad_id;
      logic       any_ready;
   } prq_stat_type;

endpackage

[src/prq_ctrl.sv]
// Sequencer for push, pop and move transactions of the ready queue.
module prq_ctrl
   import prq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  prq_stat_type stat,
   output prq_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_PUSH_DUP = 4'd2;
   localparam logic [3:0] S_FIND_LVL = 4'd3;
   localparam logic [3:0] S_POP_HEAD = 4'd4;
   localparam logic [3:0] S_POP_T    = 4'd5;
   localparam logic [3:0] S_UL_THR   = 4'd6;
   localparam logic [3:0] S_UL_LVL   = 4'd7;
   localparam logic [3:0] S_UL_WR    = 4'd8;
   localparam logic [3:0] S_MV_RD    = 4'd9;
   localparam logic [3:0] S_APPEND   = 4'd10;

   logic [3:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_PUSH: begin
                  if (stat.bad_id) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_NOTQ;
                     state_in       = S_IDLE;
                  end else if (stat.queued) begin
                     cmd.rd_thr = 1'b1;
                     state_in   = S_PUSH_DUP;
                  end else begin
                     cmd.rd_lvl = 1'b1;
                     state_in   = S_APPEND;
                  end
               end
               OP_POP: begin
                  if (!stat.any_ready) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                     cmd.rsp_zero   = 1'b1;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.find_grp = 1'b1;
                     state_in     = S_FIND_LVL;
                  end
               end
               OP_MOVE: begin
                  if (stat.bad_id || !stat.queued) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_NOTQ;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.rd_thr = 1'b1;
                     state_in   = S_UL_LVL;
                  end
               end
               default: begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = ST_OK;
                  cmd.rsp_zero   = 1'b1;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_PUSH_DUP: begin
            cmd.respond     = 1'b1;
            cmd.rsp_status  = ST_ALREADY;
            cmd.rsp_lvl_old = 1'b1;
            state_in        = S_IDLE;
         end
         S_FIND_LVL: begin
            cmd.find_lvl = 1'b1;
            state_in     = S_POP_HEAD;
         end
         S_POP_HEAD: begin
            cmd.rd_lvl = 1'b1;
            state_in   = S_POP_T;
         end
         S_POP_T: begin
            cmd.t_from_head = 1'b1;
            state_in        = S_UL_THR;
         end
         S_UL_THR: begin
            cmd.rd_thr = 1'b1;
            state_in   = S_UL_LVL;
         end
         S_UL_LVL: begin
            cmd.rd_lvl      = 1'b1;
            cmd.lvl_sel_old = 1'b1;
            state_in        = S_UL_WR;
         end
         S_UL_WR: begin
            cmd.unlink = 1'b1;
            if (stat.op == OP_POP) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_OK;
               state_in       = S_IDLE;
            end else begin
               state_in = S_MV_RD;
            end
         end
         S_MV_RD: begin
            cmd.rd_lvl = 1'b1;
            state_in   = S_APPEND;
         end
         S_APPEND: begin
            cmd.append     = 1'b1;
            cmd.respond    = 1'b1;
            cmd.rsp_status = ST_OK;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/prq_dp.sv]
// Link memories, queued flags, ready bitmap and result registers of the ready queue.
module prq_dp
   import prq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  prq_cmd_type       cmd,
   output prq_stat_type      stat,
   input  logic [1:0]        req_op,
   input  logic [ID_W-1:0]   req_thread_id,
   input  logic [LVL_W-1:0]  req_priority_req,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_result_id,
   output logic [LVL_W-1:0]  rsp_result_level,
   output logic [1:0]        rsp_status
);

   logic [ID_W-1:0]  next_mem  [NUM_THREADS];
   logic [ID_W-1:0]  prev_mem  [NUM_THREADS];
   logic [LVL_W-1:0] elev_mem  [NUM_THREADS];
   logic [ID_W-1:0]  head_mem  [NUM_LEVELS];
   logic [ID_W-1:0]  tail_mem  [NUM_LEVELS];

   logic [NUM_THREADS-1:0] queued_ff;
   logic [NUM_LEVELS-1:0]  nonempty_ff;

   logic [1:0]       op_ff;
   logic [ID_W-1:0]  t_ff;
   logic [LVL_W-1:0] lv_ff, lv_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic [SUB_W-1:0] sub_sel;
   logic [GRP_SIZE-1:0] grp_bits;

   logic [ID_W-1:0]  next_rd_ff, prev_rd_ff, head_rd_ff, tail_rd_ff;
   logic [LVL_W-1:0] elev_rd_ff;
   logic [LVL_W-1:0] lvl_ra;

   logic             next_we, prev_we, head_we, tail_we, elev_we;
   logic [ID_W-1:0]  next_wa, next_wd, prev_wa, prev_wd, head_wd, tail_wd;
   logic [LVL_W-1:0] head_wa, tail_wa;

   logic is_head, is_tail;

   logic             rsp_valid_ff;
   logic [ID_W-1:0]  rsp_id_ff;
   logic [LVL_W-1:0] rsp_lvl_ff;
   logic [1:0]       rsp_status_ff;

   assign stat.op        = op_ff;
   assign stat.queued    = queued_ff[t_ff];
   assign stat.bad_id    = ({1'b0, t_ff} >= (ID_W+1)'(NUM_THREADS));
   assign stat.any_ready = |nonempty_ff;

   // Saturate the requested level to the top level.
   always_comb begin
      if ({1'b0, req_priority_req} >= (LVL_W+1)'(NUM_LEVELS)) begin
         lv_in = LVL_W'(NUM_LEVELS - 1);
      end else begin
         lv_in = req_priority_req;
      end
   end

   // Highest ready group, then highest ready level inside it.
   always_comb begin
      grp_in = '0;
      for (int g = 0; g < NUM_GRPS; g++) begin
         if (|nonempty_ff[g*GRP_SIZE +: GRP_SIZE]) begin
            grp_in = GRP_W'(g);
         end
      end
   end

   always_comb begin
      grp_bits = nonempty_ff[grp_ff*GRP_SIZE +: GRP_SIZE];
      sub_sel  = '0;
      for (int b = 0; b < GRP_SIZE; b++) begin
         if (grp_bits[b]) begin
            sub_sel = SUB_W'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         t_ff  <= req_thread_id;
         lv_ff <= lv_in;
      end else begin
         if (cmd.t_from_head) begin
            t_ff <= head_rd_ff;
         end
         if (cmd.find_lvl) begin
            lv_ff <= {grp_ff, sub_sel};
         end
      end
      if (cmd.find_grp) begin
         grp_ff <= grp_in;
      end
   end

   assign lvl_ra  = cmd.lvl_sel_old ? elev_rd_ff : lv_ff;
   assign is_head = (head_rd_ff == t_ff);
   assign is_tail = (tail_rd_ff == t_ff);

   always_comb begin
      next_we = 1'b0; next_wa = next_rd_ff; next_wd = prev_rd_ff;
      prev_we = 1'b0; prev_wa = t_ff;       prev_wd = tail_rd_ff;
      head_we = 1'b0; head_wa = lv_ff;      head_wd = t_ff;
      tail_we = 1'b0; tail_wa = lv_ff;      tail_wd = t_ff;
      elev_we = 1'b0;
      if (cmd.unlink) begin
         head_wa = elev_rd_ff;
         tail_wa = elev_rd_ff;
         if (is_head && !is_tail) begin
            head_we = 1'b1;
            head_wd = next_rd_ff;
         end else if (is_tail && !is_head) begin
            tail_we = 1'b1;
            tail_wd = prev_rd_ff;
         end else if (!is_head && !is_tail) begin
            // Bridge the neighbors around the removed thread.
            next_we = 1'b1;
            next_wa = prev_rd_ff;
            next_wd = next_rd_ff;
            prev_we = 1'b1;
            prev_wa = next_rd_ff;
            prev_wd = prev_rd_ff;
         end
      end else if (cmd.append) begin
         tail_we = 1'b1;
         elev_we = 1'b1;
         if (nonempty_ff[lv_ff]) begin
            next_we = 1'b1;
            next_wa = tail_rd_ff;
            next_wd = t_ff;
            prev_we = 1'b1;
         end else begin
            head_we = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (elev_we) elev_mem[t_ff] <= lv_ff;
      if (head_we) head_mem[head_wa] <= head_wd;
      if (tail_we) tail_mem[tail_wa] <= tail_wd;
      if (cmd.rd_thr) begin
         next_rd_ff <= next_mem[t_ff];
         prev_rd_ff <= prev_mem[t_ff];
         elev_rd_ff <= elev_mem[t_ff];
      end
      if (cmd.rd_lvl) begin
         head_rd_ff <= head_mem[lvl_ra];
         tail_rd_ff <= tail_mem[lvl_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff   <= '0;
         nonempty_ff <= '0;
      end else if (cmd.unlink) begin
         queued_ff[t_ff] <= 1'b0;
         if (is_head && is_tail) begin
            nonempty_ff[elev_rd_ff] <= 1'b0;
         end
      end else if (cmd.append) begin
         queued_ff[t_ff]    <= 1'b1;
         nonempty_ff[lv_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.rsp_zero) begin
            rsp_id_ff  <= '0;
            rsp_lvl_ff <= '0;
         end else begin
            rsp_id_ff  <= t_ff;
            rsp_lvl_ff <= cmd.rsp_lvl_old ? elev_rd_ff : lv_ff;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_result_level = rsp_lvl_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

[src/priority_ready_queue.sv]
// Multilevel priority FIFO ready queue: push, pop highest and move between levels.
//
// A transaction is taken when start is high and busy is low; its one result shows on
// the rsp_ ports for a single cycle with rsp_valid high, and the receiver cannot stall
// it. The sequencer handles one transaction at a time over single-ported link memories
// with registered reads, and takes no new request until the result of the last one is
// out. A pop finds the highest ready level in two steps: first the highest ready group
// of eight levels, then the highest ready level inside that group.
// No clearing pass is needed after reset.
module priority_ready_queue
   import prq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_op,
   input  logic [ID_W-1:0]   req_thread_id,
   input  logic [LVL_W-1:0]  req_priority_req,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_result_id,
   output logic [LVL_W-1:0]  rsp_result_level,
   output logic [1:0]        rsp_status
);

   prq_cmd_type  cmd;
   prq_stat_type stat;

   prq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   prq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_op),
      .req_thread_id    (req_thread_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_result_id    (rsp_result_id),
      .rsp_result_level (rsp_result_level),
      .rsp_status       (rsp_status)
   );

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a transaction is in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_result_id == '0 && rsp_result_level == '0))
      else $error("empty pop reported a thread");

endmodule

[tb/tb_priority_ready_queue.sv]
// Self-checking testbench for the multilevel priority ready queue.
`timescale 1ns / 100ps

module tb_priority_ready_queue;
   import prq_pkg::*;

   typedef struct packed {
      logic [1:0]       op;
      logic [ID_W-1:0]  tid;
      logic [LVL_W-1:0] lvl;
   } sched_req_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [LVL_W-1:0] lvl;
      logic [1:0]       status;
   } sched_rsp_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_op;
   logic [ID_W-1:0]  req_thread_id;
   logic [LVL_W-1:0] req_priority_req;
   logic             rsp_valid;
   logic [ID_W-1:0]  rsp_result_id;
   logic [LVL_W-1:0] rsp_result_level;
   logic [1:0]       rsp_status;

   priority_ready_queue i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_thread_id(req_thread_id),
      .req_priority_req(req_priority_req),
      .rsp_valid(rsp_valid), .rsp_result_id(rsp_result_id),
      .rsp_result_level(rsp_result_level), .rsp_status(rsp_status)
   );

   // Shadow ready queue: one FIFO of thread ids per level.
   logic [ID_W-1:0]  shadow_fifo [NUM_LEVELS][$];
   logic             shadow_queued [NUM_THREADS];
   logic [LVL_W-1:0] shadow_level [NUM_THREADS];

   sched_req_type pending_reqs [$];
   sched_rsp_type expected_rsps [$];
   int            error_count;
   int            gap_count;

   function automatic sched_rsp_type schedule_op(sched_req_type r);
      sched_rsp_type res;
      res = '0;
      if (r.op == OP_POP) begin
         res.status = ST_EMPTY;
         for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (shadow_fifo[i].size() != 0) begin
               res.id = shadow_fifo[i].pop_front();
               res.lvl = LVL_W'(i);
               res.status = ST_OK;
               shadow_queued[res.id] = 1'b0;
               break;
            end
         end
      end else if (r.op == OP_PUSH) begin
         res.id = r.tid;
         res.lvl = r.lvl;
         if (shadow_queued[r.tid]) begin
            res.status = ST_ALREADY;
            res.lvl = shadow_level[r.tid];
         end else begin
            shadow_fifo[r.lvl].push_back(r.tid);
            shadow_queued[r.tid] = 1'b1;
            shadow_level[r.tid] = r.lvl;
         end
      end else if (r.op == OP_MOVE) begin
         res.id = r.tid;
         res.lvl = r.lvl;
         if (!shadow_queued[r.tid]) begin
            res.status = ST_NOTQ;
         end else begin
            // unlink from old level, append at tail of new one
            for (int k = 0; k < shadow_fifo[shadow_level[r.tid]].size(); k++) begin
               if (shadow_fifo[shadow_level[r.tid]][k] == r.tid) begin
                  shadow_fifo[shadow_level[r.tid]].delete(k);
                  break;
               end
            end
            shadow_fifo[r.lvl].push_back(r.tid);
            shadow_level[r.tid] = r.lvl;
         end
      end
      return res;
   endfunction

   function automatic sched_req_type make_req(logic [1:0] op, int tid, int lvl);
      sched_req_type r;
      r.op = op;
      r.tid = ID_W'(tid);
      r.lvl = LVL_W'(lvl);
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[priority_ready_queue] ERROR");
      $finish;
   end

   // Driver: hold start until the transaction is accepted; predict at the accept edge.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_count <= $urandom_range(0, 12);
      end else if (start && !busy) begin
         expected_rsps.push_back(schedule_op(make_req(req_op, req_thread_id,
                                                      req_priority_req)));
         start <= 1'b0;
         gap_count <= $urandom_range(0, 12);
      end else if (!start && pending_reqs.size() != 0) begin
         if (gap_count != 0) begin
            gap_count <= gap_count - 1;
         end else begin
            sched_req_type r;
            r = pending_reqs.pop_front();
            req_op <= r.op;
            req_thread_id <= r.tid;
            req_priority_req <= r.lvl;
            start <= 1'b1;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result id=%0d", rsp_result_id);
            error_count++;
         end else begin
            sched_rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_result_id !== e.id) begin
               $error("result_id exp %0d got %0d", e.id, rsp_result_id);
               error_count++;
            end
            if (rsp_result_level !== e.lvl) begin
               $error("result_level exp %0d got %0d", e.lvl, rsp_result_level);
               error_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      int n;
      error_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_op = '0;
      req_thread_id = '0;
      req_priority_req = '0;
      for (int i = 0; i < NUM_THREADS; i++) shadow_queued[i] = 1'b0;
      // directed part
      pending_reqs.push_back(make_req(OP_POP, 63, 63));
      pending_reqs.push_back(make_req(OP_MOVE, 5, 10));
      pending_reqs.push_back(make_req(OP_PUSH, 0, 0));
      pending_reqs.push_back(make_req(OP_PUSH, 63, 63));
      pending_reqs.push_back(make_req(OP_PUSH, 7, 63));
      pending_reqs.push_back(make_req(OP_PUSH, 8, 63));
      pending_reqs.push_back(make_req(OP_PUSH, 9, 63));
      pending_reqs.push_back(make_req(OP_PUSH, 7, 1));
      pending_reqs.push_back(make_req(OP_MOVE, 8, 63));
      pending_reqs.push_back(make_req(OP_MOVE, 7, 0));
      pending_reqs.push_back(make_req(OP_MOVE, 0, 0));
      pending_reqs.push_back(make_req(2'd3, 42, 21));
      for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(OP_POP, i, 0));
      pending_reqs.push_back(make_req(OP_POP, 0, 0));
      // random part, biased toward pushes so the queue fills
      n = 0;
      while (n < 1450) begin
         int w;
         logic [1:0] op;
         w = $urandom_range(0, 99);
         op = (w < 45) ? OP_PUSH : (w < 72) ? OP_POP : (w < 97) ? OP_MOVE : 2'd3;
         pending_reqs.push_back(make_req(op, $urandom_range(0, 63),
                                (w[0]) ? $urandom_range(0, 7) : $urandom_range(0, 63)));
         n++;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("[priority_ready_queue] OK");
      else
         $display("[priority_ready_queue] ERROR");
      $finish;
   end

endmodule
